### hdl/calendar_interval_stepper_macros.svh
// assertion macros for the checker file of the calendar interval stepper
// no dependencies; include by bare file name
`ifndef CALENDAR_INTERVAL_STEPPER_MACROS_SVH
`define CALENDAR_INTERVAL_STEPPER_MACROS_SVH

// clocked assertion that is off while reset is high
`define CIS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also checks during reset
`define CIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/cis_pkg.sv
// shared types, constants and calendar helpers for the calendar interval stepper
// no dependencies
`timescale 1ns / 1ps

package cis_pkg;

  localparam logic [14:0] YEAR_MAX      = 15'd9999;
  localparam logic [10:0] INTERVAL_MAX  = 11'd1439;
  localparam logic [10:0] INTERVAL_RST  = 11'd15;
  // floor(x / 60) == (x * 2185) >> 17 for every x up to 1439
  localparam logic [22:0] RECIP_60      = 23'd2185;

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_FWD   = 3'd1,
    CMD_STEP1 = 3'd2,
    CMD_BACK  = 3'd3,
    CMD_ALIGN = 3'd4
  } cmd_code_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_LOAD,
    ST_HOUR,
    ST_MINUTE,
    ST_ALIGN,
    ST_TRIM,
    ST_SAT,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic do_div;
    logic do_rem;
    logic do_load;
    logic do_hour;
    logic do_minute;
    logic align_step;
    logic align_trim;
    logic do_sat;
    logic push;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] command;
    logic       align_last;
    logic       out_busy;
  } ctrl_stat_t;

  // year is two's complement so a borrow below zero shows up before saturation
  typedef struct packed {
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  function automatic logic [4:0] month_length(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                         len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
      default:                      len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic date_t day_forward(input date_t d);
    date_t r;
    r = d;
    if (d.day >= month_length(d.month)) begin
      r.day = 5'd1;
      if (d.month >= 4'd12) begin
        r.month = 4'd1;
        r.year  = d.year + 15'd1;
      end else begin
        r.month = d.month + 4'd1;
      end
    end else begin
      r.day = d.day + 5'd1;
    end
    return r;
  endfunction

  function automatic date_t day_back(input date_t d);
    date_t r;
    r = d;
    if (d.day <= 5'd1) begin
      if (d.month <= 4'd1) begin
        r.month = 4'd12;
        r.day   = 5'd31;
        r.year  = d.year - 15'd1;
      end else begin
        r.month = d.month - 4'd1;
        r.day   = month_length(d.month - 4'd1);
      end
    end else begin
      r.day = d.day - 5'd1;
    end
    return r;
  endfunction

endpackage

### hdl/cis_ctrl.sv
// controller state machine of the calendar interval stepper
// depends on cis_pkg
`timescale 1ns / 1ps

module cis_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  cis_pkg::ctrl_stat_t stat,
  output cis_pkg::ctrl_cmd_t  cmd
);

  cis_pkg::state_t state;
  cis_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cis_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cis_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = cis_pkg::ST_DIV;
        end
      end
      cis_pkg::ST_DIV:  state_next = cis_pkg::ST_REM;
      cis_pkg::ST_REM: begin
        case (stat.command)
          cis_pkg::CMD_LOAD:  state_next = cis_pkg::ST_LOAD;
          cis_pkg::CMD_FWD:   state_next = cis_pkg::ST_HOUR;
          cis_pkg::CMD_STEP1: state_next = cis_pkg::ST_HOUR;
          cis_pkg::CMD_BACK:  state_next = cis_pkg::ST_HOUR;
          cis_pkg::CMD_ALIGN: state_next = cis_pkg::ST_ALIGN;
          default:            state_next = cis_pkg::ST_SAT;
        endcase
      end
      cis_pkg::ST_LOAD:   state_next = cis_pkg::ST_SAT;
      cis_pkg::ST_HOUR:   state_next = cis_pkg::ST_MINUTE;
      cis_pkg::ST_MINUTE: state_next = cis_pkg::ST_SAT;
      cis_pkg::ST_ALIGN: begin
        if (stat.align_last) begin
          state_next = cis_pkg::ST_TRIM;
        end
      end
      cis_pkg::ST_TRIM:   state_next = cis_pkg::ST_SAT;
      cis_pkg::ST_SAT:    state_next = cis_pkg::ST_DONE;
      cis_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          state_next = cis_pkg::ST_IDLE;
        end
      end
      default:            state_next = cis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      cis_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      cis_pkg::ST_DIV:    cmd.do_div     = 1'b1;
      cis_pkg::ST_REM:    cmd.do_rem     = 1'b1;
      cis_pkg::ST_LOAD:   cmd.do_load    = 1'b1;
      cis_pkg::ST_HOUR:   cmd.do_hour    = 1'b1;
      cis_pkg::ST_MINUTE: cmd.do_minute  = 1'b1;
      cis_pkg::ST_ALIGN:  cmd.align_step = 1'b1;
      cis_pkg::ST_TRIM:   cmd.align_trim = 1'b1;
      cis_pkg::ST_SAT:    cmd.do_sat     = 1'b1;
      cis_pkg::ST_DONE:   cmd.push       = !stat.out_busy;
      default: begin
        cmd      = '0;
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

### hdl/cis_datapath.sv
// datapath of the calendar interval stepper: timestamp, interval split, align divider
// depends on cis_pkg
`timescale 1ns / 1ps

module cis_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [10:0]         cfg_wr_data,
  input  logic [39:0]         s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata,
  input  cis_pkg::ctrl_cmd_t  cmd,
  output cis_pkg::ctrl_stat_t stat
);

  logic [10:0] interval_minutes;

  // captured request
  logic [2:0]  command;
  logic [13:0] ld_year;
  logic [3:0]  ld_month;
  logic [4:0]  ld_day;
  logic [4:0]  ld_hour;
  logic [5:0]  ld_minute;

  // timestamp
  logic [14:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;

  // interval split and align divider
  logic [10:0] ivl;
  logic [4:0]  hq;
  logic [4:0]  hstep;
  logic [5:0]  mstep;
  logic [5:0]  rem;
  logic [2:0]  cnt;

  logic [33:0] out_data;
  logic        out_valid;

  logic [10:0] ivl_clamp;
  logic [22:0] prod;
  logic [10:0] q_ext;
  logic [10:0] r_full;
  logic        is_back;
  logic        is_step1;

  cis_pkg::date_t cur_date;
  cis_pkg::date_t fwd_date;
  cis_pkg::date_t back_date;

  logic [5:0]  hour_sum;
  logic [5:0]  hour_wrap_val;
  logic [5:0]  hour_borrow_val;
  logic [6:0]  min_sum;
  logic [6:0]  min_borrow_val;

  logic [13:0] ld_year_c;
  logic [3:0]  ld_month_c;
  logic [4:0]  ld_len;
  logic [4:0]  ld_day_c;
  logic [4:0]  ld_hour_c;
  logic [5:0]  ld_minute_c;

  logic [6:0]  rem_sh;
  logic [10:0] rem_sub;

  assign is_back  = (command == cis_pkg::CMD_BACK);
  assign is_step1 = (command == cis_pkg::CMD_STEP1);

  // interval split: reciprocal multiply, then remainder by shift-and-subtract
  assign ivl_clamp = (interval_minutes > cis_pkg::INTERVAL_MAX) ? cis_pkg::INTERVAL_MAX
                                                               : interval_minutes;
  assign prod      = {12'd0, ivl_clamp} * cis_pkg::RECIP_60;
  assign q_ext     = {6'd0, hq};
  assign r_full    = ivl - ((q_ext << 6) - (q_ext << 2));

  assign cur_date  = '{year: year, month: month, day: day};
  assign fwd_date  = cis_pkg::day_forward(cur_date);
  assign back_date = cis_pkg::day_back(cur_date);

  assign hour_sum        = {1'b0, hour} + {1'b0, hstep};
  assign hour_wrap_val   = hour_sum - 6'd24;
  assign hour_borrow_val = {1'b0, hour} + 6'd24 - {1'b0, hstep};
  assign min_sum         = {1'b0, minute} + {1'b0, mstep};
  assign min_borrow_val  = {1'b0, minute} + 7'd60 - {1'b0, mstep};

  // load clamping
  assign ld_year_c   = (ld_year > 14'd9999) ? 14'd9999 : ld_year;
  assign ld_month_c  = (ld_month == 4'd0) ? 4'd1 : ((ld_month > 4'd12) ? 4'd12 : ld_month);
  assign ld_len      = cis_pkg::month_length(ld_month_c);
  assign ld_day_c    = (ld_day == 5'd0) ? 5'd1 : ((ld_day > ld_len) ? ld_len : ld_day);
  assign ld_hour_c   = (ld_hour > 5'd23) ? 5'd23 : ld_hour;
  assign ld_minute_c = (ld_minute > 6'd59) ? 6'd59 : ld_minute;

  // one restoring division step of the minute by the interval
  assign rem_sh  = {rem, minute[cnt]};
  assign rem_sub = {4'd0, rem_sh} - ivl;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_minutes <= cis_pkg::INTERVAL_RST;
    end else if (cfg_wr_en) begin
      interval_minutes <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year   <= 15'd0;
      month  <= 4'd1;
      day    <= 5'd1;
      hour   <= 5'd0;
      minute <= 6'd0;
    end else begin
      if (cmd.do_load) begin
        year   <= {1'b0, ld_year_c};
        month  <= ld_month_c;
        day    <= ld_day_c;
        hour   <= ld_hour_c;
        minute <= ld_minute_c;
      end
      if (cmd.do_hour) begin
        if (is_back) begin
          if (hour < hstep) begin
            hour  <= hour_borrow_val[4:0];
            year  <= back_date.year;
            month <= back_date.month;
            day   <= back_date.day;
          end else begin
            hour <= hour - hstep;
          end
        end else if (hour_sum >= 6'd24) begin
          hour  <= hour_wrap_val[4:0];
          year  <= fwd_date.year;
          month <= fwd_date.month;
          day   <= fwd_date.day;
        end else begin
          hour <= hour_sum[4:0];
        end
      end
      if (cmd.do_minute) begin
        if (is_back) begin
          if (minute < mstep) begin
            minute <= min_borrow_val[5:0];
            if (hour == 5'd0) begin
              hour  <= 5'd23;
              year  <= back_date.year;
              month <= back_date.month;
              day   <= back_date.day;
            end else begin
              hour <= hour - 5'd1;
            end
          end else begin
            minute <= minute - mstep;
          end
        end else if (min_sum >= 7'd60) begin
          minute <= min_sum[5:0] - 6'd60;
          if (hour >= 5'd23) begin
            hour  <= 5'd0;
            year  <= fwd_date.year;
            month <= fwd_date.month;
            day   <= fwd_date.day;
          end else begin
            hour <= hour + 5'd1;
          end
        end else begin
          minute <= min_sum[5:0];
        end
      end
      if (cmd.align_trim && (ivl != 11'd0)) begin
        minute <= minute - rem;
      end
      if (cmd.do_sat) begin
        if (year[14]) begin
          year   <= 15'd0;
          month  <= 4'd1;
          day    <= 5'd1;
          hour   <= 5'd0;
          minute <= 6'd0;
        end else if (year > cis_pkg::YEAR_MAX) begin
          year   <= cis_pkg::YEAR_MAX;
          month  <= 4'd12;
          day    <= 5'd31;
          hour   <= 5'd23;
          minute <= 6'd59;
        end
      end
    end
  end

  // request capture, interval split, divider and output data registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command   <= s_tdata[2:0];
      ld_year   <= s_tdata[16:3];
      ld_month  <= s_tdata[20:17];
      ld_day    <= s_tdata[25:21];
      ld_hour   <= s_tdata[30:26];
      ld_minute <= s_tdata[36:31];
    end
    if (cmd.do_div) begin
      ivl <= ivl_clamp;
      hq  <= prod[21:17];
    end
    if (cmd.do_rem) begin
      hstep <= is_step1 ? 5'd0 : hq;
      mstep <= is_step1 ? 6'd1 : r_full[5:0];
      rem   <= 6'd0;
      cnt   <= 3'd5;
    end
    if (cmd.align_step) begin
      if ({4'd0, rem_sh} >= ivl) begin
        rem <= rem_sub[5:0];
      end else begin
        rem <= rem_sh[5:0];
      end
      cnt <= cnt - 3'd1;
    end
    if (cmd.push) begin
      out_data <= {minute, hour, day, month, year[13:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid        = out_valid;
  assign m_tdata         = {6'd0, out_data};
  assign stat.command    = command;
  assign stat.align_last = (cnt == 3'd0);
  assign stat.out_busy   = out_valid && !m_tready;

endmodule

### hdl/calendar_interval_stepper.sv
// top level of the calendar interval stepper: stream ports, controller and datapath
// depends on cis_pkg, cis_ctrl, cis_datapath
`timescale 1ns / 1ps

// Calendar interval stepper. Holds a timestamp (year, month, day, hour, minute)
// and runs one command per request on the slave stream: load, forward by the
// interval, forward one minute, back by the interval, or align the minute down
// to a multiple of the interval. Every request gives exactly one result on the
// master stream carrying the timestamp after the command. Months are 28/30/31
// days with no leap years; loaded fields are clamped into range and the year
// saturates at 0000-01-01 00:00 and 9999-12-31 23:59. Codes 5 to 7 leave the
// timestamp unchanged. The interval register (11 bits, reset 15, values above
// 1439 act as 1439) is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while no request is in flight; the block does not enforce this.
// One request is worked at a time: the three step commands run interval split,
// hour phase, minute phase and saturation, and align takes its remainder from a
// six-step restoring divider that handles one minute bit per cycle. The next
// request is taken once the result has been moved into the output register,
// which holds it until the master side takes it.
module calendar_interval_stepper (
  input  logic        clk,
  input  logic        rst,
  // interval register write
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // command[2:0], load_year[16:3], load_month[20:17],
                                 // load_day[25:21], load_hour[30:26], load_minute[36:31]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // out_year[13:0], out_month[17:14], out_day[22:18],
                                 // out_hour[27:23], out_minute[33:28]
);

  // control and status between the state machine and the datapath
  cis_pkg::ctrl_cmd_t  ctrl_cmd;
  cis_pkg::ctrl_stat_t ctrl_stat;

  // sequencer: split interval, run command phases, saturate, push result
  cis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (ctrl_stat),
    .cmd      (ctrl_cmd)
  );

  // timestamp, interval register, divider and output register
  cis_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cmd         (ctrl_cmd),
    .stat        (ctrl_stat)
  );

endmodule

### hdl/cis_checker.sv
// port-level checker for the calendar interval stepper, bound to the top level
// depends on calendar_interval_stepper_macros.svh and calendar_interval_stepper
`timescale 1ns / 1ps
`include "calendar_interval_stepper_macros.svh"

module cis_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  logic out_stall;
  logic stamp_ok;

  assign out_stall = m_tvalid && !m_tready;
  assign stamp_ok  = (m_tdata[13:0] <= 14'd9999) && (m_tdata[17:14] != 4'd0) &&
                     (m_tdata[17:14] <= 4'd12) && (m_tdata[22:18] != 5'd0) &&
                     (m_tdata[27:23] <= 5'd23) && (m_tdata[33:28] <= 6'd59);

  // a stalled result holds
  `CIS_ASSERT(a_out_hold, clk, rst, out_stall |=> m_tvalid && $stable(m_tdata), "result moved")

  // every result has year, month, hour and minute in range and a nonzero day
  `CIS_ASSERT(a_out_range, clk, rst, m_tvalid |-> stamp_ok, "timestamp out of range")

  // one request in work at a time
  `CIS_ASSERT(a_one_in_flight, clk, rst, s_tvalid && s_tready |=> !s_tready, "request while busy")

  // reset empties the output register
  `CIS_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind calendar_interval_stepper cis_checker u_cis_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### test/tb.sv
// testbench for calendar_interval_stepper: a directed plan and random command requests,
// each result checked field by field against its typed value or a timestamp predictor
// depends on cis_pkg and calendar_interval_stepper
`timescale 1ns / 1ps

module tb;

  // command codes outside the enum, all three leave the timestamp alone
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int PHASE_ITEMS   = 200;
  localparam int PHASE_COUNT   = 10;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF      = 300;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } stamp_t;

  // one line of the directed plan: an interval write or a request
  typedef struct packed {
    logic        is_cfg;
    logic [10:0] cfg_value;
    logic [39:0] request;
    logic        typed;
    stamp_t      want;
  } plan_row_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  calendar_interval_stepper u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the timestamp and the interval register
  int          ts_year, ts_month, ts_day, ts_hour, ts_minute;
  logic [10:0] interval_reg = cis_pkg::INTERVAL_RST;

  stamp_t    pending_stamps[$];
  stamp_t    oldest_stamp;
  plan_row_t plan_rows[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int requests_done = 0;
  int results_seen = 0;
  int interval_writes = 0;
  int year_saturations = 0;
  int cmd_count[8];

  function automatic int month_days(input int m);
    if (m == 2)
      return 28;
    if (m == 4 || m == 6 || m == 9 || m == 11)
      return 30;
    return 31;
  endfunction

  function automatic void next_day();
    if (ts_day >= month_days(ts_month)) begin
      ts_day = 1;
      if (ts_month >= 12) begin
        ts_month = 1;
        ts_year++;
      end else begin
        ts_month++;
      end
    end else begin
      ts_day++;
    end
  endfunction

  function automatic void prev_day();
    if (ts_day <= 1) begin
      if (ts_month <= 1) begin
        ts_month = 12;
        ts_day   = 31;
        ts_year--;
      end else begin
        ts_month--;
        ts_day = month_days(ts_month);
      end
    end else begin
      ts_day--;
    end
  endfunction

  // hour part first, then the minute part with its own carry
  function automatic void advance_by(input int h, input int m);
    if (ts_hour + h >= 24) begin
      ts_hour = ts_hour + h - 24;
      next_day();
    end else begin
      ts_hour = ts_hour + h;
    end
    if (ts_minute + m >= 60) begin
      ts_minute = ts_minute + m - 60;
      if (ts_hour + 1 >= 24) begin
        ts_hour = 0;
        next_day();
      end else begin
        ts_hour++;
      end
    end else begin
      ts_minute = ts_minute + m;
    end
  endfunction

  function automatic void rewind_by(input int h, input int m);
    if (ts_hour < h) begin
      ts_hour = ts_hour + 24 - h;
      prev_day();
    end else begin
      ts_hour = ts_hour - h;
    end
    if (ts_minute < m) begin
      ts_minute = ts_minute + 60 - m;
      if (ts_hour == 0) begin
        ts_hour = 23;
        prev_day();
      end else begin
        ts_hour--;
      end
    end else begin
      ts_minute = ts_minute - m;
    end
  endfunction

  function automatic stamp_t mk_stamp(input int y, input int mo, input int d, input int h,
                                      input int mi);
    stamp_t s;
    s.year   = 14'(y);
    s.month  = 4'(mo);
    s.day    = 5'(d);
    s.hour   = 5'(h);
    s.minute = 6'(mi);
    return s;
  endfunction

  function automatic logic [39:0] pack_request(input logic [2:0] code, input logic [13:0] y,
                                               input logic [3:0] mo, input logic [4:0] d,
                                               input logic [4:0] h, input logic [5:0] mi);
    return {3'b000, mi, h, d, mo, y, code};
  endfunction

  // runs one request on the predictor state and returns the timestamp after it
  function automatic stamp_t apply_request(input logic [39:0] req);
    int         ivl;
    int         v;
    int         ymax;
    logic [2:0] code;
    code = req[2:0];
    ymax = int'(cis_pkg::YEAR_MAX);
    ivl  = (interval_reg > cis_pkg::INTERVAL_MAX) ? int'(cis_pkg::INTERVAL_MAX)
                                                  : int'(interval_reg);
    cmd_count[code]++;
    case (code)
      cis_pkg::CMD_LOAD: begin
        v = int'(req[16:3]);
        ts_year = (v > ymax) ? ymax : v;
        v = int'(req[20:17]);
        ts_month = (v < 1) ? 1 : ((v > 12) ? 12 : v);
        v = int'(req[25:21]);
        if (v < 1)
          v = 1;
        if (v > month_days(ts_month))
          v = month_days(ts_month);
        ts_day = v;
        v = int'(req[30:26]);
        ts_hour = (v > 23) ? 23 : v;
        v = int'(req[36:31]);
        ts_minute = (v > 59) ? 59 : v;
      end
      cis_pkg::CMD_FWD:   advance_by(ivl / 60, ivl % 60);
      cis_pkg::CMD_STEP1: advance_by(0, 1);
      cis_pkg::CMD_BACK:  rewind_by(ivl / 60, ivl % 60);
      cis_pkg::CMD_ALIGN: begin
        if (ivl != 0)
          ts_minute = ts_minute - (ts_minute % ivl);
      end
      default: ;
    endcase
    // pin the timestamp to the first or last representable minute
    if (ts_year > ymax) begin
      year_saturations++;
      ts_year = ymax;
      ts_month = 12;
      ts_day = 31;
      ts_hour = 23;
      ts_minute = 59;
    end else if (ts_year < 0) begin
      year_saturations++;
      ts_year = 0;
      ts_month = 1;
      ts_day = 1;
      ts_hour = 0;
      ts_minute = 0;
    end
    return mk_stamp(ts_year, ts_month, ts_day, ts_hour, ts_minute);
  endfunction

  // mostly well-formed loads and steps, some aligns and unknown codes, with raw
  // out-of-range loads and loads parked next to the year limits so saturation gets hit
  function automatic logic [39:0] random_request();
    logic [2:0]  code;
    logic [13:0] y;
    logic [3:0]  mo;
    logic [4:0]  d, h;
    logic [5:0]  mi;
    int          pick;
    y  = 14'($urandom);
    mo = 4'($urandom);
    d  = 5'($urandom);
    h  = 5'($urandom);
    mi = 6'($urandom);
    pick = $urandom_range(99);
    if (pick < 14) begin
      code = cis_pkg::CMD_LOAD;
      case ($urandom_range(4))
        0: ;  // raw field bits, clamped by the block
        1: begin
          if ($urandom_range(1)) begin
            y  = 14'(cis_pkg::YEAR_MAX);
            mo = 4'd12;
            d  = 5'd31;
            h  = 5'($urandom_range(23, 20));
          end else begin
            y  = 14'd0;
            mo = 4'd1;
            d  = 5'd1;
            h  = 5'($urandom_range(3));
          end
          mi = 6'($urandom_range(59));
        end
        default: begin
          y  = 14'($urandom_range(9999));
          mo = 4'($urandom_range(12, 1));
          d  = 5'($urandom_range(month_days(mo), 1));
          h  = 5'($urandom_range(23));
          mi = 6'($urandom_range(59));
          // park at a month end or a month start so carries ripple
          case ($urandom_range(3))
            0: begin
              d = 5'(month_days(mo));
              h = 5'd23;
            end
            1: begin
              d = 5'd1;
              h = 5'd0;
            end
            default: ;
          endcase
        end
      endcase
    end else if (pick < 40) begin
      code = cis_pkg::CMD_FWD;
    end else if (pick < 60) begin
      code = cis_pkg::CMD_STEP1;
    end else if (pick < 85) begin
      code = cis_pkg::CMD_BACK;
    end else if (pick < 95) begin
      code = cis_pkg::CMD_ALIGN;
    end else begin
      code = 3'($urandom_range(7, 5));
    end
    return pack_request(code, y, mo, d, h, mi);
  endfunction

  function automatic void add_row(input logic is_cfg, input logic [10:0] cfg_value,
                                  input logic [39:0] request, input logic typed,
                                  input stamp_t want);
    plan_row_t r;
    r.is_cfg    = is_cfg;
    r.cfg_value = cfg_value;
    r.request   = request;
    r.typed     = typed;
    r.want      = want;
    plan_rows.push_back(r);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin gap_pct = 49; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 49; end
      IDLE_BOTH:     begin gap_pct = 12; stall_pct = 12; end
      default:       begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // called and returns at a falling edge; valid stays high after the handshake
  // so back-to-back requests never drop it
  task automatic offer(input logic [39:0] req, input logic typed, input stamp_t want);
    stamp_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 40'({$urandom, $urandom}) & 40'h1F_FFFF_FFFF;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    predicted = apply_request(req);
    // typed rows still advance the predictor but are checked against the typed value
    pending_stamps.push_back(typed ? want : predicted);
    requests_done++;
    @(negedge clk);
  endtask

  // stop offering and let every pending result drain before touching the register
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_stamps.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_interval(input logic [10:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    interval_reg = value;
    interval_writes++;
  endtask

  // receiver: a long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker, oldest pending timestamp first
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_stamps.size() == 0) begin
        $error("result with no request pending: tdata %h", m_tdata);
        mismatches++;
      end else begin
        oldest_stamp = pending_stamps.pop_front();
        check_field("out_year",   oldest_stamp.year,   m_tdata[13:0]);
        check_field("out_month",  oldest_stamp.month,  m_tdata[17:14]);
        check_field("out_day",    oldest_stamp.day,    m_tdata[22:18]);
        check_field("out_hour",   oldest_stamp.hour,   m_tdata[27:23]);
        check_field("out_minute", oldest_stamp.minute, m_tdata[33:28]);
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("calendar_interval_stepper verification failed");
    $finish;
  end

  initial begin
    logic [10:0] phase_ivl;
    idle_mode_t  phase_mode;
    int          directed;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    ts_year     = 0;
    ts_month    = 1;
    ts_day      = 1;
    ts_hour     = 0;
    ts_minute   = 0;
    foreach (cmd_count[i])
      cmd_count[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed plan, interval at its reset value of 15 until the first write
    add_row(0, 0, pack_request(CMD_RSVD5, 0, 0, 0, 0, 0), 1, mk_stamp(0, 1, 1, 0, 0));
    add_row(0, 0, pack_request(cis_pkg::CMD_BACK, 0, 0, 0, 0, 0), 1, mk_stamp(0, 1, 1, 0, 0));
    add_row(0, 0, pack_request(cis_pkg::CMD_LOAD, 14'h3FFF, 4'hF, 5'h1F, 5'h1F, 6'h3F), 1,
            mk_stamp(9999, 12, 31, 23, 59));
    add_row(0, 0, pack_request(cis_pkg::CMD_STEP1, 0, 0, 0, 0, 0), 1,
            mk_stamp(9999, 12, 31, 23, 59));
    add_row(0, 0, pack_request(cis_pkg::CMD_FWD, 0, 0, 0, 0, 0), 1,
            mk_stamp(9999, 12, 31, 23, 59));
    add_row(0, 0, pack_request(cis_pkg::CMD_LOAD, 0, 0, 0, 0, 0), 1, mk_stamp(0, 1, 1, 0, 0));
    // day past the end of february and april gets clamped
    add_row(0, 0, pack_request(cis_pkg::CMD_LOAD, 1234, 2, 31, 5, 7), 1,
            mk_stamp(1234, 2, 28, 5, 7));
    add_row(0, 0, pack_request(cis_pkg::CMD_ALIGN, 0, 0, 0, 0, 0), 1,
            mk_stamp(1234, 2, 28, 5, 0));
    // year rollover forward and back
    add_row(0, 0, pack_request(cis_pkg::CMD_LOAD, 100, 12, 31, 23, 59), 1,
            mk_stamp(100, 12, 31, 23, 59));
    add_row(0, 0, pack_request(cis_pkg::CMD_STEP1, 0, 0, 0, 0, 0), 1,
            mk_stamp(101, 1, 1, 0, 0));
    add_row(0, 0, pack_request(cis_pkg::CMD_BACK, 0, 0, 0, 0, 0), 1,
            mk_stamp(100, 12, 31, 23, 45));
    add_row(0, 0, pack_request(cis_pkg::CMD_LOAD, 500, 4, 31, 0, 0), 1,
            mk_stamp(500, 4, 30, 0, 0));
    add_row(0, 0, pack_request(cis_pkg::CMD_BACK, 0, 0, 0, 0, 0), 1,
            mk_stamp(500, 4, 29, 23, 45));
    add_row(0, 0, pack_request(CMD_RSVD6, 14'h3FFF, 4'hF, 5'h1F, 5'h1F, 6'h3F), 0, '0);
    add_row(0, 0, pack_request(CMD_RSVD7, 0, 0, 0, 0, 0), 0, '0);
    // zero interval: steps and align change nothing
    add_row(1, 11'd0, '0, 0, '0);
    add_row(0, 0, pack_request(cis_pkg::CMD_FWD, 0, 0, 0, 0, 0), 0, '0);
    add_row(0, 0, pack_request(cis_pkg::CMD_ALIGN, 0, 0, 0, 0, 0), 0, '0);
    // interval above the limit acts as 1439
    add_row(1, 11'h7FF, '0, 0, '0);
    add_row(0, 0, pack_request(cis_pkg::CMD_FWD, 0, 0, 0, 0, 0), 0, '0);
    add_row(0, 0, pack_request(cis_pkg::CMD_BACK, 0, 0, 0, 0, 0), 0, '0);
    // align with an interval of an hour or more clears the minute
    add_row(1, 11'd60, '0, 0, '0);
    add_row(0, 0, pack_request(cis_pkg::CMD_LOAD, 9999, 12, 31, 0, 59), 0, '0);
    add_row(0, 0, pack_request(cis_pkg::CMD_ALIGN, 0, 0, 0, 0, 0), 0, '0);

    set_idle(IDLE_NONE);
    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_cfg) begin
        settle();
        write_interval(plan_rows[i].cfg_value);
      end else begin
        offer(plan_rows[i].request, plan_rows[i].typed, plan_rows[i].want);
      end
    end
    directed = requests_done;

    // random phases, each under its own interval and idling pattern
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       begin phase_ivl = 11'd1;    phase_mode = IDLE_NONE;     end
        1:       begin phase_ivl = 11'd59;   phase_mode = IDLE_SENDER;   end
        2:       begin phase_ivl = 11'd60;   phase_mode = IDLE_RECEIVER; end
        3:       begin phase_ivl = 11'd61;   phase_mode = IDLE_BOTH;     end
        4:       begin phase_ivl = 11'd1439; phase_mode = IDLE_NONE;     end
        5:       begin phase_ivl = 11'd0;    phase_mode = IDLE_SENDER;   end
        6:       begin phase_ivl = 11'd1440; phase_mode = IDLE_RECEIVER; end
        7:       begin phase_ivl = 11'h7FF;  phase_mode = IDLE_BOTH;     end
        8:       begin phase_ivl = 11'($urandom_range(1439, 1)); phase_mode = IDLE_NONE; end
        default: begin phase_ivl = 11'($urandom_range(2047));    phase_mode = IDLE_RECEIVER; end
      endcase
      settle();
      write_interval(phase_ivl);
      set_idle(phase_mode);
      if (p == 8) begin
        // receiver backs off while requests keep coming, so the input side stalls
        @(posedge clk);
        hold_cycles = HOLD_OFF;
        @(negedge clk);
      end
      repeat (PHASE_ITEMS) offer(random_request(), 1'b0, '0);
    end
    settle();

    $display("covered %0d requests (%0d directed), %0d results checked, %0d interval writes",
             requests_done, directed, results_seen, interval_writes);
    $display("load %0d, forward %0d, one minute %0d, back %0d, align %0d, unknown %0d",
             cmd_count[cis_pkg::CMD_LOAD], cmd_count[cis_pkg::CMD_FWD],
             cmd_count[cis_pkg::CMD_STEP1], cmd_count[cis_pkg::CMD_BACK],
             cmd_count[cis_pkg::CMD_ALIGN],
             cmd_count[CMD_RSVD5] + cmd_count[CMD_RSVD6] + cmd_count[CMD_RSVD7]);
    $display("%0d year saturations", year_saturations);
    if (mismatches == 0) begin
      $display("calendar_interval_stepper verification clean");
    end else begin
      $display("calendar_interval_stepper verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/cis_pkg.sv
hdl/cis_ctrl.sv
hdl/cis_datapath.sv
hdl/calendar_interval_stepper.sv
hdl/cis_checker.sv
test/tb.sv
